// ----- src/adnp_pkg.sv -----
`timescale 1ns / 1ps

package adnp_pkg;

  // Default configuration
  localparam int MAX_FRACTION_DIGITS_DEF = 9;
  localparam int FRACTION_BITS_DEF       = 32;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Width of the fraction accumulator (holds up to 10^9 - 1)
  localparam int FSUM_W = 30;

  // Input transaction
  typedef struct packed {
    logic       kind;
    logic [7:0] char_code;
  } adnp_in_t;

  // Result transaction
  typedef struct packed {
    logic               ok;
    logic signed [31:0] int_value;
    logic signed [63:0] fixed_value;
  } adnp_out_t;

  // Controller to datapath
  typedef struct packed {
    logic char_go;
    logic div_step;
    logic fin_go;
    logic out_load;
  } adnp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic term;
    logic out_free;
  } adnp_sts_t;

  // Powers of ten for the fraction divisor
  function automatic logic [FSUM_W-1:0] pow10(input logic [3:0] n);
    logic [FSUM_W-1:0] p;
    p = '0;
    unique case (n)
      4'd0:    p = 30'd1;
      4'd1:    p = 30'd10;
      4'd2:    p = 30'd100;
      4'd3:    p = 30'd1000;
      4'd4:    p = 30'd10000;
      4'd5:    p = 30'd100000;
      4'd6:    p = 30'd1000000;
      4'd7:    p = 30'd10000000;
      4'd8:    p = 30'd100000000;
      4'd9:    p = 30'd1000000000;
      default: p = 30'd1000000000;
    endcase
    return p;
  endfunction

endpackage

// ----- src/ascii_decimal_number_parser_core.sv -----
`timescale 1ns / 1ps

// ASCII decimal number parser.
// in_data carries one character per transaction plus the kind bit
// (integer or decimal), taken from the first character of each string.
// A NUL character (code 00) ends the string and produces one result transaction
// on out_data: ok flag, saturated int32, or signed fixed point with
// FRACTION_BITS fraction bits, rounded to nearest.
// Ordinary characters are taken without a stall; in_stall stays low for them.
// A terminator runs a restoring divider, one quotient bit per cycle, for
// FRACTION_BITS + 1 quotient bits, then forms the magnitude in one step;
// in_stall is high from when the terminator is taken until the result is
// loaded into the output register.
// A finished result sits in the output register; if out_stall holds it
// there, the next string's characters are still taken and only the next
// terminator's result waits for the register to drain, with in_stall
// high while it waits.
// Reset (rst_n low, synchronous) clears the parse state and drops any
// pending result.
module ascii_decimal_number_parser_core #(
  parameter int MAX_FRACTION_DIGITS = adnp_pkg::MAX_FRACTION_DIGITS_DEF,
  parameter int FRACTION_BITS       = adnp_pkg::FRACTION_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  adnp_pkg::adnp_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output adnp_pkg::adnp_out_t out_data
);

  adnp_pkg::adnp_cmd_t cmd;
  adnp_pkg::adnp_sts_t sts;

  // Controller
  adnp_ctrl #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath
  adnp_dpath #(
    .MAX_FRACTION_DIGITS (MAX_FRACTION_DIGITS),
    .FRACTION_BITS       (FRACTION_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- src/adnp_ctrl.sv -----
`timescale 1ns / 1ps

module adnp_ctrl #(
  parameter int FRACTION_BITS = adnp_pkg::FRACTION_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  adnp_pkg::adnp_sts_t sts,
  output adnp_pkg::adnp_cmd_t cmd
);

  localparam int CW = $clog2(FRACTION_BITS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIN,
    ST_OUT
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.char_go = 1'b1;
          if (sts.term) begin
            state_nxt = ST_DIV;
            cnt_nxt   = '0;
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + CW'(1);
        if (cnt_r == CW'(FRACTION_BITS)) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        cmd.fin_go = 1'b1;
        state_nxt  = ST_OUT;
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ----- src/adnp_dpath.sv -----
`timescale 1ns / 1ps

module adnp_dpath #(
  parameter int MAX_FRACTION_DIGITS = adnp_pkg::MAX_FRACTION_DIGITS_DEF,
  parameter int FRACTION_BITS       = adnp_pkg::FRACTION_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  adnp_pkg::adnp_in_t  in_data,
  input  adnp_pkg::adnp_cmd_t cmd,
  output adnp_pkg::adnp_sts_t sts,
  output logic                out_valid,
  input  logic                out_stall,
  output adnp_pkg::adnp_out_t out_data
);

  localparam int FW = adnp_pkg::FSUM_W;
  localparam int FB = FRACTION_BITS;
  localparam int NW = FW + FB + 1;

  typedef enum logic [1:0] {
    PH_START,
    PH_WHOLE,
    PH_FRAC,
    PH_BAD
  } phase_t;

  // Parse state
  phase_t        phase_r;
  logic          kind_r;
  logic          neg_r;
  logic [31:0]   whole_r;
  logic          wseen_r;
  logic [FW-1:0] fsum_r;
  logic [3:0]    fcnt_r;
  logic          fseen_r;
  logic          failed_r;

  // Snapshot taken at the terminator
  logic          t_ok_r;
  logic          t_kind_r;
  logic          t_neg_r;
  logic [31:0]   t_whole_r;
  logic [FW-1:0] div_r;
  logic [FW-1:0] rem_r;
  logic [FB:0]   qn_r;
  logic [63:0]   mag_r;
  logic          sat_r;

  logic          out_valid_r;
  adnp_pkg::adnp_out_t out_r;

  // Character decode
  logic       is_digit;
  logic [3:0] dig;
  logic [7:0] ch;
  assign ch       = in_data.char_code;
  assign is_digit = (ch >= adnp_pkg::CH_ZERO) && (ch <= adnp_pkg::CH_NINE);
  assign dig      = is_digit ? 4'(ch - adnp_pkg::CH_ZERO) : 4'd0;

  assign sts.term     = (ch == adnp_pkg::CH_NUL);
  assign sts.out_free = !out_valid_r || !out_stall;

  // Accumulate: x*10 + d
  logic [35:0] whole_mul;
  logic [31:0] whole_add;
  logic [FW-1:0] fsum_add;
  assign whole_mul = {1'b0, whole_r, 3'b0} + {3'b0, whole_r, 1'b0} + 36'(dig);
  assign whole_add = (whole_mul[35:32] != 4'd0) ? 32'hFFFF_FFFF : whole_mul[31:0];
  assign fsum_add  = FW'({fsum_r, 3'b0} + {2'b0, fsum_r, 1'b0} + (FW + 3)'(dig));

  logic frac_room;
  assign frac_room = (fcnt_r < 4'(MAX_FRACTION_DIGITS));

  // Numerator of the rounded fraction: fsum * 2^F + 10^cnt / 2
  logic [FW-1:0] p10;
  logic [NW-1:0] num;
  assign p10 = adnp_pkg::pow10(fcnt_r);
  assign num = (NW'(fsum_r) << FB) + NW'(p10 >> 1);

  logic term_ok;
  assign term_ok = !failed_r && (phase_r != PH_START) && (wseen_r || fseen_r);

  // Restoring divider step
  logic [FW:0]   rem_sh;
  logic          rem_ge;
  logic [FW:0]   rem_diff;
  assign rem_sh   = {rem_r, qn_r[FB]};
  assign rem_ge   = rem_sh >= {1'b0, div_r};
  assign rem_diff = rem_sh - {1'b0, div_r};

  // Parse registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_START;
      kind_r   <= 1'b0;
      neg_r    <= 1'b0;
      whole_r  <= '0;
      wseen_r  <= 1'b0;
      fsum_r   <= '0;
      fcnt_r   <= '0;
      fseen_r  <= 1'b0;
      failed_r <= 1'b0;
    end else if (cmd.char_go) begin
      if (sts.term) begin
        phase_r  <= PH_START;
        kind_r   <= 1'b0;
        neg_r    <= 1'b0;
        whole_r  <= '0;
        wseen_r  <= 1'b0;
        fsum_r   <= '0;
        fcnt_r   <= '0;
        fseen_r  <= 1'b0;
        failed_r <= 1'b0;
      end else begin
        unique case (phase_r)
          PH_START: begin
            kind_r <= in_data.kind;
            priority if (ch == adnp_pkg::CH_MINUS) begin
              phase_r <= PH_WHOLE;
              neg_r   <= 1'b1;
            end else if (ch == adnp_pkg::CH_PLUS) begin
              phase_r <= PH_WHOLE;
            end else if (is_digit) begin
              phase_r <= PH_WHOLE;
              whole_r <= whole_add;
              wseen_r <= 1'b1;
            end else if (ch == adnp_pkg::CH_POINT && in_data.kind) begin
              phase_r <= PH_FRAC;
            end else begin
              phase_r  <= PH_WHOLE;
              failed_r <= 1'b1;
            end
          end
          PH_WHOLE: begin
            priority if (is_digit) begin
              whole_r <= whole_add;
              wseen_r <= 1'b1;
            end else if (ch == adnp_pkg::CH_POINT && kind_r) begin
              phase_r <= PH_FRAC;
            end else begin
              failed_r <= 1'b1;
            end
          end
          PH_FRAC: begin
            if (is_digit) begin
              fseen_r <= 1'b1;
              if (frac_room) begin
                fsum_r <= fsum_add;
                fcnt_r <= fcnt_r + 4'd1;
              end
            end else begin
              failed_r <= 1'b1;
            end
          end
          default: failed_r <= 1'b1;
        endcase
      end
    end
  end

  // Snapshot, divider and magnitude
  always_ff @(posedge clk) begin
    if (cmd.char_go && sts.term) begin
      t_ok_r    <= term_ok;
      t_kind_r  <= kind_r;
      t_neg_r   <= neg_r;
      t_whole_r <= whole_r;
      div_r     <= p10;
      rem_r     <= num[NW-1:FB+1];
      qn_r      <= num[FB:0];
    end else if (cmd.div_step) begin
      rem_r <= rem_ge ? rem_diff[FW-1:0] : rem_sh[FW-1:0];
      qn_r  <= {qn_r[FB-1:0], rem_ge};
    end
    if (cmd.fin_go) begin
      mag_r <= (64'(t_whole_r) << FB) + 64'(qn_r);
      sat_r <= (64'(t_whole_r) >> (63 - FB)) != 64'd0;
    end
  end

  // Final saturation and sign
  logic [63:0] lim;
  logic [63:0] mag_c;
  logic [63:0] fix_v;
  logic [31:0] int_v;
  assign lim   = t_neg_r ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
  assign mag_c = (sat_r || (mag_r > lim)) ? lim : mag_r;
  assign fix_v = t_neg_r ? (64'd0 - mag_c) : mag_c;

  always_comb begin
    if (t_neg_r) begin
      int_v = t_whole_r[31] ? 32'h8000_0000 : (32'd0 - t_whole_r);
    end else begin
      int_v = t_whole_r[31] ? 32'h7FFF_FFFF : t_whole_r;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.ok          <= t_ok_r;
      out_r.int_value   <= (t_ok_r && !t_kind_r) ? int_v : 32'sd0;
      out_r.fixed_value <= (t_ok_r && t_kind_r) ? fix_v : 64'sd0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
